// ===== sv/obd_pid_text_response_decoder_macros.svh =====
// Assertion macros used by the OBD PID text decoder back end.
`ifndef OBD_PID_TEXT_RESPONSE_DECODER_MACROS_SVH
`define OBD_PID_TEXT_RESPONSE_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define OBDP_ASSERT_IMM(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define OBDP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/obdp_pkg.sv =====
// Shared types, constants and helpers of the OBD PID text decoder.
package obdp_pkg;

   // character codes
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // reply header and PIDs
   localparam logic [7:0] MODE01_REPLY = 8'h41;
   localparam logic [7:0] PID_COOLANT  = 8'h05;
   localparam logic [7:0] PID_RPM      = 8'h0C;
   localparam logic [7:0] PID_SPEED    = 8'h0D;
   localparam logic [7:0] PID_FUEL     = 8'h2F;
   localparam logic [7:0] PID_BATTERY  = 8'h42;
   localparam logic [7:0] PID_PEDAL    = 8'h49;
   localparam logic [7:0] PID_OIL      = 8'h5C;

   // result item codes
   localparam logic [2:0] ITEM_COOLANT = 3'd0;
   localparam logic [2:0] ITEM_RPM     = 3'd1;
   localparam logic [2:0] ITEM_SPEED   = 3'd2;
   localparam logic [2:0] ITEM_FUEL    = 3'd3;
   localparam logic [2:0] ITEM_BATTERY = 3'd4;
   localparam logic [2:0] ITEM_PEDAL   = 3'd5;
   localparam logic [2:0] ITEM_OIL     = 3'd6;

   localparam int          TOKENS_MAX  = 4;
   localparam logic [2:0] TOKENS_FULL = 3'd4;
   localparam logic [2:0] TOKENS_MIN  = 3'd3;

   // queue between classifier and tokenizer
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   typedef enum logic [1:0] {
      CLS_HEX,
      CLS_SEP,
      CLS_CR,
      CLS_STOP
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
   } qentry_type;

   typedef struct packed {
      logic       valid;
      qentry_type entry;
   } q_head_type;

   // floor(n / 255) for n below 2^23: reciprocal estimate, then one correction
   function automatic logic [15:0] div255(input logic [22:0] n);
      logic [31:0] prod;
      logic [15:0] q0;
      logic [23:0] q255;
      logic [23:0] rem;
      prod = {9'd0, n} + {1'b0, n, 8'd0};
      q0   = prod[31:16];
      q255 = {q0, 8'd0} - {8'd0, q0};
      rem  = {1'b0, n} - q255;
      if (rem >= 24'd255) begin
         q0 = q0 + 16'd1;
      end
      return q0;
   endfunction

endpackage

// ===== sv/obdp_front.sv =====
// Front end: classifies each received character and queues it.
module obdp_front (
   input  logic                 req_valid,
   input  logic [7:0]           req_rx_byte,
   input  logic                 q_full,
   output logic                 req_stall,
   output logic                 push,
   output obdp_pkg::qentry_type push_entry
);

   obdp_pkg::char_class_type cls;
   logic [3:0]               digit;

   // character classification
   always_comb begin
      cls   = obdp_pkg::CLS_STOP;
      digit = 4'd0;
      if (req_rx_byte == obdp_pkg::CHAR_CR) begin
         cls = obdp_pkg::CLS_CR;
      end else if (req_rx_byte == obdp_pkg::CHAR_SPACE || req_rx_byte == obdp_pkg::CHAR_TAB ||
                   req_rx_byte == obdp_pkg::CHAR_LF) begin
         cls = obdp_pkg::CLS_SEP;
      end else if (req_rx_byte >= 8'h30 && req_rx_byte <= 8'h39) begin
         cls   = obdp_pkg::CLS_HEX;
         digit = 4'(req_rx_byte - 8'h30);
      end else if (req_rx_byte >= 8'h61 && req_rx_byte <= 8'h66) begin
         cls   = obdp_pkg::CLS_HEX;
         digit = 4'(req_rx_byte - 8'h57);
      end else if (req_rx_byte >= 8'h41 && req_rx_byte <= 8'h46) begin
         cls   = obdp_pkg::CLS_HEX;
         digit = 4'(req_rx_byte - 8'h37);
      end
   end

   // handshake into the queue
   assign req_stall        = q_full;
   assign push             = req_valid && !q_full;
   assign push_entry.cls   = cls;
   assign push_entry.digit = digit;

endmodule

// ===== sv/obdp_queue.sv =====
// Short queue of classified characters between front and back ends.
module obdp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  obdp_pkg::qentry_type push_entry,
   input  logic                 pop,
   output logic                 q_full,
   output obdp_pkg::q_head_type head
);

   obdp_pkg::qentry_type        mem_ff [obdp_pkg::Q_DEPTH];
   logic [obdp_pkg::Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [obdp_pkg::Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [obdp_pkg::Q_AW:0]     cnt_ff, cnt_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign q_full     = (cnt_ff == (obdp_pkg::Q_AW + 1)'(obdp_pkg::Q_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

endmodule

// ===== sv/obdp_back.sv =====
// Back end: token assembly, line decode and result register.
`include "obd_pid_text_response_decoder_macros.svh"

module obdp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  obdp_pkg::q_head_type head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_item_code,
   output logic signed [16:0]   rsp_item_value
);

   logic [7:0]         tok_ff [obdp_pkg::TOKENS_MAX];
   logic [7:0]         tok_in [obdp_pkg::TOKENS_MAX];
   logic [7:0]         acc_ff, acc_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               inside_ff, inside_in;
   logic               stopped_ff, stopped_in;
   logic               dropped_ff, dropped_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         code_ff, code_in;
   logic signed [16:0] value_ff, value_in;

   logic               out_free;
   logic               is_cr;
   logic               do_finish;
   logic               fin_cr;
   logic [7:0]         eff_tok [obdp_pkg::TOKENS_MAX];
   logic [2:0]         eff_cnt;
   logic [7:0]         tok_a;
   logic [7:0]         tok_b;
   logic               pid_known;
   logic               hit;
   logic [2:0]         dec_code;
   logic signed [16:0] dec_value;
   logic [22:0]        div_num;
   logic [15:0]        div_q;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_cr    = (head.entry.cls == obdp_pkg::CLS_CR);
   assign pop      = head.valid && (!is_cr || out_free);

   // line as seen at carriage return, pending token included
   always_comb begin
      fin_cr  = !stopped_ff && inside_ff && (cnt_ff < obdp_pkg::TOKENS_FULL);
      eff_cnt = cnt_ff + {2'd0, fin_cr};
      for (int i = 0; i < obdp_pkg::TOKENS_MAX; i++) begin
         eff_tok[i] = (fin_cr && cnt_ff[1:0] == 2'(i)) ? acc_ff : tok_ff[i];
      end
      tok_a = eff_tok[2];
      tok_b = (eff_cnt >= obdp_pkg::TOKENS_FULL) ? eff_tok[3] : 8'd0;
   end

   // shared divide-by-255 for fuel and pedal
   always_comb begin
      if (eff_tok[1] == obdp_pkg::PID_FUEL) begin
         div_num = ({15'd0, tok_a} << 14) + ({15'd0, tok_a} << 13) +
                   ({15'd0, tok_a} << 10) + 23'd127;
      end else begin
         div_num = ({15'd0, tok_a} << 6) + ({15'd0, tok_a} << 5) +
                   ({15'd0, tok_a} << 2);
      end
      div_q = obdp_pkg::div255(div_num);
   end

   // PID decoder
   always_comb begin
      pid_known = 1'b1;
      dec_code  = obdp_pkg::ITEM_COOLANT;
      dec_value = '0;
      unique case (eff_tok[1])
         obdp_pkg::PID_COOLANT: begin
            dec_code  = obdp_pkg::ITEM_COOLANT;
            dec_value = $signed({9'd0, tok_a}) - 17'sd40;
         end
         obdp_pkg::PID_RPM: begin
            dec_code  = obdp_pkg::ITEM_RPM;
            dec_value = $signed({3'd0, tok_a, tok_b[7:2]});
         end
         obdp_pkg::PID_SPEED: begin
            dec_code  = obdp_pkg::ITEM_SPEED;
            dec_value = $signed({9'd0, tok_a});
         end
         obdp_pkg::PID_FUEL: begin
            dec_code  = obdp_pkg::ITEM_FUEL;
            dec_value = $signed({1'b0, div_q});
         end
         obdp_pkg::PID_BATTERY: begin
            dec_code  = obdp_pkg::ITEM_BATTERY;
            dec_value = $signed({1'b0, tok_a, tok_b});
         end
         obdp_pkg::PID_PEDAL: begin
            dec_code  = obdp_pkg::ITEM_PEDAL;
            dec_value = $signed({1'b0, div_q});
         end
         obdp_pkg::PID_OIL: begin
            dec_code  = obdp_pkg::ITEM_OIL;
            dec_value = $signed({9'd0, tok_a}) - 17'sd40;
         end
         default: begin
            pid_known = 1'b0;
         end
      endcase
      hit = !dropped_ff && (eff_cnt >= obdp_pkg::TOKENS_MIN) &&
            (eff_tok[0] == obdp_pkg::MODE01_REPLY) && pid_known;
   end

   // tokenizer next state
   always_comb begin
      tok_in     = tok_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      inside_in  = inside_ff;
      stopped_in = stopped_ff;
      dropped_in = dropped_ff;
      do_finish  = 1'b0;
      if (pop) begin
         unique case (head.entry.cls)
            obdp_pkg::CLS_CR: begin
               acc_in     = '0;
               cnt_in     = '0;
               inside_in  = 1'b0;
               stopped_in = 1'b0;
               dropped_in = 1'b0;
            end
            obdp_pkg::CLS_SEP: begin
               do_finish = !stopped_ff;
            end
            obdp_pkg::CLS_STOP: begin
               do_finish  = !stopped_ff;
               stopped_in = 1'b1;
            end
            obdp_pkg::CLS_HEX: begin
               if (!stopped_ff) begin
                  if (inside_ff && acc_ff[7:4] != 4'd0) begin
                     // token above 255: drop the line
                     dropped_in = 1'b1;
                     stopped_in = 1'b1;
                     inside_in  = 1'b0;
                     acc_in     = '0;
                  end else begin
                     acc_in    = {acc_ff[3:0], head.entry.digit};
                     inside_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (do_finish) begin
         if (inside_ff && cnt_ff < obdp_pkg::TOKENS_FULL) begin
            tok_in[cnt_ff[1:0]] = acc_ff;
            cnt_in              = cnt_ff + 3'd1;
            if (cnt_ff == obdp_pkg::TOKENS_FULL - 3'd1) begin
               stopped_in = 1'b1;
            end
         end
         inside_in = 1'b0;
         acc_in    = '0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      code_in      = code_ff;
      value_in     = value_ff;
      if (pop && is_cr && hit) begin
         rsp_valid_in = 1'b1;
         code_in      = dec_code;
         value_in     = dec_value;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         inside_ff    <= 1'b0;
         stopped_ff   <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         inside_ff    <= inside_in;
         stopped_ff   <= stopped_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tok_ff   <= tok_in;
      code_ff  <= code_in;
      value_ff <= value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_code  = code_ff;
   assign rsp_item_value = value_ff;

   `OBDP_ASSERT_IMM(a_full_stops, clock, reset,
      cnt_ff == obdp_pkg::TOKENS_FULL, stopped_ff, "four tokens kept but scan still running")
   `OBDP_ASSERT_IMM(a_drop_stops, clock, reset,
      dropped_ff, stopped_ff && !inside_ff, "dropped line still scanning")
   `OBDP_ASSERT_NXT(a_rsp_retire, clock, reset,
      rsp_valid_ff && !rsp_stall && !(pop && is_cr), !rsp_valid_ff, "taken result still shown")
   `OBDP_ASSERT_IMM(a_no_overwrite, clock, reset,
      rsp_valid_ff && rsp_stall, !(pop && is_cr), "line end consumed while result waits")

endmodule

// ===== sv/obd_pid_text_response_decoder.sv =====
// Path: a carriage return item is written into the queue, popped by the tokenizer, and its
// result is registered in the result register; queued items ahead of it retire first.
// Throughput: one character item per cycle while the queue has room; the tokenizer retires one queue
// entry a cycle. A waiting result stalls only carriage returns; other items keep draining the queue.
// The four-entry queue lets the input run on while the result side stalls.
// Reset (synchronous, active high) empties the queue, clears line state and the result.
module obd_pid_text_response_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_item_code,
   output logic signed [16:0]  rsp_item_value
);

   logic                 push;
   logic                 pop;
   logic                 q_full;
   obdp_pkg::qentry_type push_entry;
   obdp_pkg::q_head_type head;

   obdp_front u_front (
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_entry  (push_entry)
   );

   obdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_full     (q_full),
      .head       (head)
   );

   obdp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item_code  (rsp_item_code),
      .rsp_item_value (rsp_item_value)
   );

endmodule
